>>> hdl/weno_pkg.sv
// Shared types, widths and constants of the WENO interface reconstruction.
// Used by weno_reconstruction and the port checker.
package weno_pkg;

    localparam int unsigned FRAC_BITS_DEF = 24;
    localparam int unsigned STEN_W        = 32;
    localparam int unsigned P_W           = 37;  // candidate numerators over 6
    localparam int unsigned DIF_W         = 36;  // signed stencil differences
    localparam int unsigned DM_W          = 35;  // difference magnitudes
    localparam int unsigned DMS_W         = 29;  // magnitudes after the common shift
    localparam int unsigned G_MAX         = DM_W - DMS_W;
    localparam int unsigned G_W           = 3;
    localparam int unsigned SQ_W          = 2 * DMS_W;
    localparam int unsigned S_W           = 63;  // eps + 12*beta
    localparam int unsigned RATIO_BITS    = 28;
    localparam int unsigned Q_W           = RATIO_BITS + 1;
    localparam int unsigned QQ_W          = 2 * Q_W;
    localparam int unsigned A_W           = 60;  // alpha and its sum
    localparam int unsigned WEIGHT_BITS   = 26;
    localparam int unsigned W_W           = WEIGHT_BITS + 1;
    localparam int unsigned PROD_W        = 64;
    localparam int unsigned X_W           = PROD_W - WEIGHT_BITS - 1;
    localparam int unsigned D3_STEP       = 7;   // quotient bits per divide-by-3 stage
    localparam int unsigned D3_N          = 5;
    localparam int unsigned D3_PW         = D3_STEP * D3_N;

    typedef struct packed {
        logic signed [STEN_W-1:0] stencil_0;
        logic signed [STEN_W-1:0] stencil_1;
        logic signed [STEN_W-1:0] stencil_2;
        logic signed [STEN_W-1:0] stencil_3;
        logic signed [STEN_W-1:0] stencil_4;
        logic                     right_biased;
    } in_t;

    typedef struct packed {
        logic signed [STEN_W-1:0] recon_value;
        logic                     saturated;
    } out_t;

    // 12e-6 in units of 2^-(2*frac-2*g), rounded, at least 1
    function automatic logic [S_W-1:0] eps_calc(input int unsigned frac,
                                                  input int unsigned g);
        logic [63:0] e;
        int          sh;
        sh = 2 * int'(frac) - 2 * int'(g);
        if (sh < 0) sh = 0;
        if (sh > 60) sh = 60;
        e = ((64'd12 << sh) + 64'd500000) / 64'd1000000;
        if (e == 64'd0) e = 64'd1;
        return S_W'(e);
    endfunction

endpackage

>>> hdl/weno_fdiv.sv
// Pipelined restoring fraction divider: quo = floor(num * 2^BITS / den), num <= den.
// One quotient bit per register stage. Uses no package.
module weno_fdiv #(
    parameter int unsigned W    = 63,
    parameter int unsigned BITS = 28
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [W-1:0]  num_in,
    input  logic [W-1:0]  den_in,
    output logic [BITS:0] quo
);

    logic [W-1:0]  r_reg [BITS];
    logic [W-1:0]  d_reg [BITS];
    logic [BITS:0] q_reg [BITS+1];
    logic          ge0;

    assign ge0 = (num_in >= den_in);

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= (BITS+1)'(ge0);
            r_reg[0] <= ge0 ? num_in - den_in : num_in;
            d_reg[0] <= den_in;
        end
    end

    for (genvar i = 1; i <= BITS; i++) begin : g_step
        logic [W:0]    r2;
        logic          ge;
        logic [W-1:0]  r_next;
        logic [BITS:0] q_next;

        always_comb begin
            r2     = {r_reg[i-1], 1'b0};
            ge     = (r2 >= {1'b0, d_reg[i-1]});
            r_next = ge ? W'(r2 - {1'b0, d_reg[i-1]}) : W'(r2);
            q_next = {q_reg[i-1][BITS-1:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i] <= q_next;
            end
        end

        if (i < BITS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i] <= r_next;
                    d_reg[i] <= d_reg[i-1];
                end
            end
        end
    end

    assign quo = q_reg[BITS];

endmodule

>>> hdl/weno_reconstruction.sv
// Top level of the WENO (Jiang-Shu) interface reconstruction pipeline.
// Depends on weno_pkg and weno_fdiv.
//
// Takes one stencil word per clock and returns one result word per clock while not
// stalled. Most of the depth lies in the two long-division pipelines (weight ratios,
// then normalized weights) that retire one quotient bit per stage. The whole pipeline
// stalls as one while the output word waits; s_ready is low only then. order_five is
// sampled when a word enters, and should be written only while the pipeline is empty.
module weno_reconstruction #(
    parameter int unsigned FRAC_BITS = weno_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  weno_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output weno_pkg::out_t  m_data,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);

    localparam int unsigned STEN_W = weno_pkg::STEN_W;
    localparam int unsigned P_W    = weno_pkg::P_W;
    localparam int unsigned DIF_W  = weno_pkg::DIF_W;
    localparam int unsigned DM_W   = weno_pkg::DM_W;
    localparam int unsigned DMS_W  = weno_pkg::DMS_W;
    localparam int unsigned G_MAX  = weno_pkg::G_MAX;
    localparam int unsigned G_W    = weno_pkg::G_W;
    localparam int unsigned SQ_W   = weno_pkg::SQ_W;
    localparam int unsigned S_W    = weno_pkg::S_W;
    localparam int unsigned Q_W    = weno_pkg::Q_W;
    localparam int unsigned QQ_W   = weno_pkg::QQ_W;
    localparam int unsigned A_W    = weno_pkg::A_W;
    localparam int unsigned W_W    = weno_pkg::W_W;
    localparam int unsigned PROD_W = weno_pkg::PROD_W;
    localparam int unsigned X_W    = weno_pkg::X_W;
    localparam int unsigned D3_N   = weno_pkg::D3_N;
    localparam int unsigned D3_PW  = weno_pkg::D3_PW;
    localparam int unsigned D3_STEP = weno_pkg::D3_STEP;
    localparam int unsigned RL     = weno_pkg::RATIO_BITS + 1;
    localparam int unsigned WL     = weno_pkg::WEIGHT_BITS + 1;
    localparam int unsigned NV     = 6 + RL + 3 + WL + 4 + D3_N;

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(3) << weno_pkg::WEIGHT_BITS;
    localparam logic signed [X_W-1:0]    X_HI = X_W'(64'sd6442450944);   // 3 * 2^31
    localparam logic signed [X_W-1:0]    X_LO = X_W'(-64'sd6442450944);
    localparam logic [W_W-1:0]           W_ONE = W_W'(1) << weno_pkg::WEIGHT_BITS;

    typedef struct packed {
        logic [2:0][P_W-1:0] p;
        logic                five;
    } pay_t;

    logic          en;
    logic          order_five_reg;
    logic [NV-1:0] vld_reg;
    logic          m_valid_reg;
    weno_pkg::out_t m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_five_reg <= 1'b1;
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) order_five_reg <= cfg_wr_data;
            if (en) begin
                vld_reg     <= {vld_reg[NV-2:0], s_valid};
                m_valid_reg <= vld_reg[NV-1];
            end
        end
    end

    // ---- stage 1: stencil select and reversal
    logic signed [STEN_W-1:0] x_in [5];
    logic signed [STEN_W-1:0] v_next [5];
    logic signed [STEN_W-1:0] st1_v_reg [5];
    logic                     st1_five_reg;

    always_comb begin
        x_in[0] = s_data.stencil_0;
        x_in[1] = s_data.stencil_1;
        x_in[2] = s_data.stencil_2;
        x_in[3] = s_data.stencil_3;
        x_in[4] = s_data.stencil_4;
        for (int i = 0; i < 5; i++) v_next[i] = '0;
        if (order_five_reg) begin
            for (int i = 0; i < 5; i++)
                v_next[i] = s_data.right_biased ? x_in[4-i] : x_in[i];
        end else begin
            for (int i = 0; i < 3; i++)
                v_next[i] = s_data.right_biased ? x_in[2-i] : x_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_v_reg    <= v_next;
            st1_five_reg <= order_five_reg;
        end
    end

    // ---- stage 2: candidates and difference magnitudes
    logic signed [P_W-1:0]   a, b, c, d, e;
    logic signed [DIF_W-1:0] dif [6];
    pay_t                    pay2_next, pay2_reg;
    logic [DM_W-1:0]         dm_next [6];
    logic [DM_W-1:0]         st2_dm_reg [6];

    always_comb begin
        a = P_W'(st1_v_reg[0]);
        b = P_W'(st1_v_reg[1]);
        c = P_W'(st1_v_reg[2]);
        d = P_W'(st1_v_reg[3]);
        e = P_W'(st1_v_reg[4]);
        pay2_next.five = st1_five_reg;
        for (int i = 0; i < 6; i++) dif[i] = '0;
        if (st1_five_reg) begin
            pay2_next.p[0] = P_W'(2 * a - 7 * b + 11 * c);
            pay2_next.p[1] = P_W'(-b + 5 * c + 2 * d);
            pay2_next.p[2] = P_W'(2 * c + 5 * d - e);
            dif[0] = DIF_W'(a - 2 * b + c);
            dif[1] = DIF_W'(a - 4 * b + 3 * c);
            dif[2] = DIF_W'(b - 2 * c + d);
            dif[3] = DIF_W'(b - d);
            dif[4] = DIF_W'(c - 2 * d + e);
            dif[5] = DIF_W'(3 * c - 4 * d + e);
        end else begin
            pay2_next.p[0] = P_W'(-3 * a + 9 * b);
            pay2_next.p[1] = P_W'(3 * b + 3 * c);
            pay2_next.p[2] = '0;
            dif[0] = DIF_W'(b - a);
            dif[1] = DIF_W'(c - b);
        end
        for (int i = 0; i < 6; i++)
            dm_next[i] = dif[i][DIF_W-1] ? DM_W'(-dif[i]) : DM_W'(dif[i]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay2_reg   <= pay2_next;
            st2_dm_reg <= dm_next;
        end
    end

    // ---- stage 3: common shift so every magnitude fits DMS_W bits
    logic [DM_W-1:0]  dm_or;
    logic [G_W-1:0]   g_next;
    logic [DMS_W-1:0] dms_next [6];
    pay_t             pay3_reg;
    logic [G_W-1:0]   st3_g_reg;
    logic [DMS_W-1:0] st3_dms_reg [6];

    always_comb begin
        dm_or = '0;
        for (int i = 0; i < 6; i++) dm_or = dm_or | st2_dm_reg[i];
        g_next = '0;
        // the OR shares its leading one with the maximum
        for (int j = 1; j <= int'(G_MAX); j++)
            if (dm_or[DMS_W-1+j]) g_next = G_W'(j);
        for (int i = 0; i < 6; i++) dms_next[i] = DMS_W'(st2_dm_reg[i] >> g_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay3_reg    <= pay2_reg;
            st3_g_reg   <= g_next;
            st3_dms_reg <= dms_next;
        end
    end

    // ---- stage 4: squares and eps
    logic [S_W-1:0]  eps_tab [G_MAX+1];
    pay_t            pay4_reg;
    logic [SQ_W-1:0] st4_sq_reg [6];
    logic [S_W-1:0]  st4_eps_reg;

    for (genvar gi = 0; gi <= G_MAX; gi++) begin : g_eps
        assign eps_tab[gi] = weno_pkg::eps_calc(FRAC_BITS, gi);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay4_reg    <= pay3_reg;
            st4_eps_reg <= eps_tab[st3_g_reg];
            for (int i = 0; i < 6; i++)
                st4_sq_reg[i] <= SQ_W'(st3_dms_reg[i]) * SQ_W'(st3_dms_reg[i]);
        end
    end

    // ---- stage 5: s_k = eps + 12*beta_k
    logic [S_W-1:0] s_next [3];
    pay_t           pay5_reg;
    logic [S_W-1:0] st5_s_reg [3];

    always_comb begin
        if (pay4_reg.five) begin
            for (int k = 0; k < 3; k++)
                s_next[k] = st4_eps_reg + S_W'(13) * S_W'(st4_sq_reg[2*k])
                          + S_W'(3) * S_W'(st4_sq_reg[2*k+1]);
        end else begin
            for (int k = 0; k < 2; k++)
                s_next[k] = st4_eps_reg + S_W'(12) * S_W'(st4_sq_reg[k]);
            s_next[2] = st4_eps_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay5_reg  <= pay4_reg;
            st5_s_reg <= s_next;
        end
    end

    // ---- stage 6: minimum
    logic [S_W-1:0] smin_next;
    pay_t           pay6_reg;
    logic [S_W-1:0] st6_s_reg [3];
    logic [S_W-1:0] st6_smin_reg;

    always_comb begin
        smin_next = (st5_s_reg[1] < st5_s_reg[0]) ? st5_s_reg[1] : st5_s_reg[0];
        if (pay5_reg.five && st5_s_reg[2] < smin_next) smin_next = st5_s_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay6_reg     <= pay5_reg;
            st6_s_reg    <= st5_s_reg;
            st6_smin_reg <= smin_next;
        end
    end

    // ---- ratio division q_k = smin * 2^RATIO_BITS / s_k
    logic [Q_W-1:0] q_div [3];
    pay_t           dl1_reg [RL];

    for (genvar k = 0; k < 3; k++) begin : g_rdiv
        weno_fdiv #(
            .W    (S_W),
            .BITS (weno_pkg::RATIO_BITS)
        ) u_rdiv (
            .aclk   (aclk),
            .en     (en),
            .num_in (st6_smin_reg),
            .den_in (st6_s_reg[k]),
            .quo    (q_div[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl1_reg[0] <= pay6_reg;
            for (int i = 1; i < int'(RL); i++) dl1_reg[i] <= dl1_reg[i-1];
        end
    end

    // ---- q squared, alpha, sum
    pay_t            pay36_reg, pay37_reg, pay38_reg;
    logic [QQ_W-1:0] qq_reg [3];
    logic [A_W-1:0]  al37_reg [3];
    logic [A_W-1:0]  al38_reg [3];
    logic [A_W-1:0]  sum38_reg;
    logic [2:0]      lin [3];

    always_comb begin
        if (pay36_reg.five) begin
            lin[0] = 3'd1; lin[1] = 3'd6; lin[2] = 3'd3;
        end else begin
            lin[0] = 3'd1; lin[1] = 3'd2; lin[2] = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay36_reg <= dl1_reg[RL-1];
            for (int k = 0; k < 3; k++)
                qq_reg[k] <= QQ_W'(q_div[k]) * QQ_W'(q_div[k]);
            pay37_reg <= pay36_reg;
            for (int k = 0; k < 3; k++)
                al37_reg[k] <= A_W'(qq_reg[k]) * A_W'(lin[k]);
            pay38_reg <= pay37_reg;
            al38_reg  <= al37_reg;
            sum38_reg <= al37_reg[0] + al37_reg[1] + al37_reg[2];
        end
    end

    // ---- weight division w_k = alpha_k * 2^WEIGHT_BITS / sum, for k = 0 and 1
    logic [W_W-1:0] w_div [2];
    pay_t           dl2_reg [WL];

    for (genvar k = 0; k < 2; k++) begin : g_wdiv
        weno_fdiv #(
            .W    (A_W),
            .BITS (weno_pkg::WEIGHT_BITS)
        ) u_wdiv (
            .aclk   (aclk),
            .en     (en),
            .num_in (al38_reg[k]),
            .den_in (sum38_reg),
            .quo    (w_div[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl2_reg[0] <= pay38_reg;
            for (int i = 1; i < int'(WL); i++) dl2_reg[i] <= dl2_reg[i-1];
        end
    end

    // ---- weights, products, numerator
    logic [W_W-1:0]           w_next [3];
    pay_t                     pay66_reg;
    logic [W_W-1:0]           w66_reg [3];
    logic signed [PROD_W-1:0] prod67_reg [3];
    logic signed [PROD_W-1:0] nb68_reg;

    always_comb begin
        w_next[0] = w_div[0];
        if (dl2_reg[WL-1].five) begin
            w_next[1] = w_div[1];
            w_next[2] = W_ONE - w_div[0] - w_div[1];
        end else begin
            w_next[1] = W_ONE - w_div[0];
            w_next[2] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay66_reg <= dl2_reg[WL-1];
            w66_reg   <= w_next;
            for (int k = 0; k < 3; k++)
                prod67_reg[k] <= PROD_W'($signed({1'b0, w66_reg[k]})
                                 * $signed(pay66_reg.p[k]));
            nb68_reg <= prod67_reg[0] + prod67_reg[1] + prod67_reg[2] + HALF;
        end
    end

    // ---- range check; floor(nb / (3 * 2^27)) = floor(floor(nb / 2^27) / 3)
    logic signed [X_W-1:0] x69;
    logic                  hi69_reg, lo69_reg;
    logic [D3_PW-1:0]      u69_reg;

    assign x69 = X_W'(nb68_reg >>> (weno_pkg::WEIGHT_BITS + 1));

    always_ff @(posedge aclk) begin
        if (en) begin
            hi69_reg <= (x69 >= X_HI);
            lo69_reg <= (x69 < X_LO);
            u69_reg  <= D3_PW'(x69 + X_HI);
        end
    end

    // ---- divide by 3, D3_STEP quotient bits per stage
    logic [D3_PW-1:0] d3_u_reg [D3_N];
    logic [1:0]       d3_r_reg [D3_N];
    logic [D3_PW-1:0] d3_q_reg [D3_N];
    logic             d3_hi_reg [D3_N];
    logic             d3_lo_reg [D3_N];

    for (genvar k = 0; k < D3_N; k++) begin : g_div3
        logic [D3_PW-1:0] u_in, u_c, q_c;
        logic [1:0]       r_in, r_c;
        logic [2:0]       t;
        logic             hi_in, lo_in;

        if (k == 0) begin : g_first
            assign u_in  = u69_reg;
            assign r_in  = 2'd0;
            assign hi_in = hi69_reg;
            assign lo_in = lo69_reg;
            always_comb begin
                q_c = '0;
                u_c = u_in;
                r_c = r_in;
                t   = '0;
                for (int j = 0; j < int'(D3_STEP); j++) begin
                    t   = {r_c, u_c[D3_PW-1]};
                    u_c = u_c << 1;
                    q_c = {q_c[D3_PW-2:0], t >= 3'd3};
                    if (t >= 3'd3) t = t - 3'd3;
                    r_c = t[1:0];
                end
            end
        end else begin : g_next
            assign u_in  = d3_u_reg[k-1];
            assign r_in  = d3_r_reg[k-1];
            assign hi_in = d3_hi_reg[k-1];
            assign lo_in = d3_lo_reg[k-1];
            always_comb begin
                q_c = d3_q_reg[k-1];
                u_c = u_in;
                r_c = r_in;
                t   = '0;
                for (int j = 0; j < int'(D3_STEP); j++) begin
                    t   = {r_c, u_c[D3_PW-1]};
                    u_c = u_c << 1;
                    q_c = {q_c[D3_PW-2:0], t >= 3'd3};
                    if (t >= 3'd3) t = t - 3'd3;
                    r_c = t[1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d3_u_reg[k]  <= u_c;
                d3_r_reg[k]  <= r_c;
                d3_q_reg[k]  <= q_c;
                d3_hi_reg[k] <= hi_in;
                d3_lo_reg[k] <= lo_in;
            end
        end
    end

    // ---- output word
    weno_pkg::out_t m_data_next;

    always_comb begin
        if (d3_hi_reg[D3_N-1]) begin
            m_data_next.recon_value = 32'sh7fff_ffff;
            m_data_next.saturated   = 1'b1;
        end else if (d3_lo_reg[D3_N-1]) begin
            m_data_next.recon_value = 32'sh8000_0000;
            m_data_next.saturated   = 1'b1;
        end else begin
            // quotient is biased by 2^31
            m_data_next.recon_value = $signed(d3_q_reg[D3_N-1][STEN_W-1:0] ^ 32'h8000_0000);
            m_data_next.saturated   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> hdl/weno_chk.sv
// Port-level checker for weno_reconstruction, attached by bind.
// Depends on weno_pkg for the word types.
module weno_chk (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input weno_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_sat_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.recon_value == 32'sh7fff_ffff || m_data.recon_value == 32'sh8000_0000))
        else $error("saturated flag without a clipped value");

endmodule

bind weno_reconstruction weno_chk u_weno_chk (.*);
